>>> hdl/hde_pkg.sv
// Shared types and constants of the histogram equalizer.
package hde_pkg;

    localparam int PIXEL_W         = 8;
    localparam int LEVELS_DEF      = 256;
    localparam int MAX_PIXELS_DEF  = 4194304;
    localparam logic [PIXEL_W-1:0] MAX_LEVEL_RESET = 8'd255;

    localparam logic CMD_COUNT = 1'b0;
    localparam logic CMD_MAP   = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [PIXEL_W-1:0] pixel;
        logic               last;
    } t_in;

    typedef struct packed {
        logic [PIXEL_W-1:0] out_pixel;
        logic               out_last;
    } t_out;

    // Classified operation passed from the front end to the engine.
    typedef struct packed {
        logic               cmd;
        logic [PIXEL_W-1:0] idx;
        logic               last;
    } t_op;

endpackage

>>> hdl/histogram_equalizer.sv
// Histogram equalizer top level: front end, operation queue and engine.
//
// Items enter on start/busy: an item is taken at a clock edge with start high
// and busy low. Count items (cmd 0) add the pixel to the frame histogram; the
// count item marked last starts a prefix-sum sweep over the bins, one RAM read
// and one write back per grey level. Map items (cmd 1) give one result: o_strobe
// is high for one cycle with o_result holding the equalized level. A mapped pixel
// keeps the engine through a RAM read, a scale multiply and eight restoring divide
// steps, one bit per cycle, before its result is registered and strobed. A map
// item that needs no divide is answered straight from idle, and a count item
// passes through the count state that writes its bin back.
// A two-entry queue sits between the front end and the engine, so busy only
// rises when the engine falls behind by two items.
// The max_level register is written over i_cfg_valid/o_cfg_ready, which is
// always ready; write it only while no item is in flight.
// Reset (i_rst_n low, synchronous) empties the queue, clears the histogram
// through per-bin valid flags and sets max_level to 255. Results are never
// held: the receiver must take each strobed result in its cycle.
module histogram_equalizer #(
    parameter int LEVELS     = hde_pkg::LEVELS_DEF,
    parameter int MAX_PIXELS = hde_pkg::MAX_PIXELS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  hde_pkg::t_in                i_item,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [hde_pkg::PIXEL_W-1:0] i_cfg_data,
    output logic                        o_strobe,
    output hde_pkg::t_out               o_result
);
    import hde_pkg::*;

    t_op  op;
    logic op_valid, op_ready;

    hde_front #(.LEVELS(LEVELS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_op_valid (op_valid),
        .i_op_ready (op_ready),
        .o_op       (op)
    );

    hde_back #(.LEVELS(LEVELS), .MAX_PIXELS(MAX_PIXELS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (op_valid),
        .o_op_ready  (op_ready),
        .i_op        (op),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );
endmodule

>>> hdl/hde_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hde_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> hdl/hde_front.sv
// Front end: accepts items, saturates the level index and queues operations.
module hde_front #(
    parameter int LEVELS = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  hde_pkg::t_in  i_item,
    output logic          o_op_valid,
    input  logic          i_op_ready,
    output hde_pkg::t_op  o_op
);
    import hde_pkg::*;

    t_op        r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_op        n_op;
    logic       push, pop;

    always_comb begin
        n_op.cmd  = i_item.cmd;
        n_op.last = i_item.last;
        if ({1'b0, i_item.pixel} >= (PIXEL_W+1)'(LEVELS)) begin
            n_op.idx = PIXEL_W'(LEVELS - 1);
        end else begin
            n_op.idx = i_item.pixel;
        end
    end

    assign busy       = (r_cnt == 2'd2);
    assign push       = start && !busy;
    assign o_op_valid = (r_cnt != 2'd0);
    assign pop        = o_op_valid && i_op_ready;
    assign o_op       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_op;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

>>> hdl/hde_back.sv
// Engine: bin updates, prefix-sum sweep, and the rounded mapping divide.
module hde_back #(
    parameter int LEVELS     = 256,
    parameter int MAX_PIXELS = 4194304
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_op_valid,
    output logic                        o_op_ready,
    input  hde_pkg::t_op                i_op,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [hde_pkg::PIXEL_W-1:0] i_cfg_data,
    output logic                        o_strobe,
    output hde_pkg::t_out               o_result
);
    import hde_pkg::*;

    localparam int LW   = $clog2(LEVELS);
    localparam int CW   = $clog2(MAX_PIXELS + 1);
    localparam int NUMW = CW + PIXEL_W + 2;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CNT    = 3'd1;
    localparam logic [2:0] S_PRE_RD = 3'd2;
    localparam logic [2:0] S_PRE_WR = 3'd3;
    localparam logic [2:0] S_MUL    = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;

    logic [2:0]         r_state;
    logic [LEVELS-1:0]  r_valid;
    logic               r_rd_ok;
    logic [CW-1:0]      r_total;
    logic               r_ready;
    logic [PIXEL_W-1:0] r_ml;
    logic [LW-1:0]      r_idx, r_k;
    logic               r_last;
    logic [CW-1:0]      r_sum;
    logic [NUMW-1:0]    r_num;
    logic [CW:0]        r_den;
    logic [PIXEL_W-1:0] r_q;
    logic [2:0]         r_bit;
    logic               r_strobe;
    t_out               r_out;

    logic [LW-1:0]         raddr, waddr;
    logic                  we;
    logic [CW-1:0]         wdata, rdata, bin;
    logic [NUMW-1:0]       trial;
    logic [CW-1:0]         n_sum;
    logic [CW+PIXEL_W-1:0] prod;
    logic                  n_strobe;

    hde_ram #(.W(CW), .DEPTH(LEVELS)) u_bins (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Entries not written since the last frame clear read as zero.
    assign bin   = r_rd_ok ? rdata : '0;
    assign n_sum = r_sum + bin;
    assign trial = NUMW'(r_den) << r_bit;
    assign prod  = r_ml * bin;

    // A result leaves either straight from idle (no divide needed) or after the last divide step.
    assign n_strobe = ((r_state == S_IDLE) && i_op_valid && (i_op.cmd == CMD_MAP) &&
                       (!r_ready || r_total == '0)) ||
                      ((r_state == S_DIV) && (r_bit == 3'd0));

    assign o_op_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = r_strobe;
    assign o_result    = r_out;

    always_comb begin
        raddr = (r_state == S_PRE_RD) ? r_k : i_op.idx[LW-1:0];
        we    = 1'b0;
        waddr = r_idx;
        wdata = bin + CW'(1);
        if (r_state == S_CNT) begin
            we = 1'b1;
        end else if (r_state == S_PRE_WR) begin
            we    = 1'b1;
            waddr = r_k;
            wdata = n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ok <= r_valid[raddr];
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_total  <= '0;
            r_ready  <= 1'b0;
            r_ml     <= MAX_LEVEL_RESET;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= n_strobe;
            if (i_cfg_valid) begin
                r_ml <= i_cfg_data;
            end
            if (we) begin
                r_valid[waddr] <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_op_valid) begin
                        r_idx  <= i_op.idx[LW-1:0];
                        r_last <= i_op.last;
                        r_k    <= '0;
                        r_sum  <= '0;
                        if (i_op.cmd == CMD_COUNT) begin
                            if (!r_ready) begin
                                if (r_total < CW'(MAX_PIXELS)) begin
                                    r_state <= S_CNT;
                                end else if (i_op.last) begin
                                    r_state <= S_PRE_RD;
                                end
                            end
                        end else if (!r_ready || r_total == '0) begin
                            r_out.out_pixel    <= '0;
                            r_out.out_last     <= i_op.last;
                            if (i_op.last) begin
                                r_valid <= '0;
                                r_total <= '0;
                                r_ready <= 1'b0;
                            end
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_CNT: begin
                    r_total <= r_total + CW'(1);
                    r_state <= r_last ? S_PRE_RD : S_IDLE;
                end
                S_PRE_RD: begin
                    r_state <= S_PRE_WR;
                end
                S_PRE_WR: begin
                    r_sum <= n_sum;
                    if (r_k == LW'(LEVELS - 1)) begin
                        r_ready <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_k     <= r_k + LW'(1);
                        r_state <= S_PRE_RD;
                    end
                end
                S_MUL: begin
                    // num = 2*max_level*cdf + total, den = 2*total.
                    r_num   <= NUMW'({prod, 1'b0}) + NUMW'(r_total);
                    r_den   <= {r_total, 1'b0};
                    r_q     <= '0;
                    r_bit   <= 3'(PIXEL_W - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_num >= trial) begin
                        r_num        <= r_num - trial;
                        r_q[r_bit]   <= 1'b1;
                    end
                    if (r_bit == 3'd0) begin
                        r_out.out_pixel <= (r_num >= trial) ? (r_q | 8'd1) : r_q;
                        r_out.out_last  <= r_last;
                        if (r_last) begin
                            r_valid <= '0;
                            r_total <= '0;
                            r_ready <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end else begin
                        r_bit <= r_bit - 3'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
